[sv/sensor_frame_decoder_macros.svh]
// Assertion helpers for the RTL file that checks itself.
`ifndef SENSOR_FRAME_DECODER_MACROS_SVH
`define SENSOR_FRAME_DECODER_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define SFD_ASSERT_ALWAYS(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// A condition that must be followed by another one at the next clock edge.
`define SFD_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

[sv/sfd_pkg.sv]
package sfd_pkg;

   // Frame store geometry.
   localparam int FRAME_BYTES_MAX = 64;
   localparam int POS_W           = $clog2(FRAME_BYTES_MAX + 1);
   localparam int ADDR_W          = $clog2(FRAME_BYTES_MAX);
   localparam int CAP_BYTES       = 15;
   localparam int CAP_IDX_W       = $clog2(CAP_BYTES);

   // First payload byte and the last payload byte each kind needs.
   localparam logic [ADDR_W-1:0] FIRST_DATA = ADDR_W'(3);
   localparam logic [ADDR_W-1:0] LAST_GPS   = ADDR_W'(17);
   localparam logic [ADDR_W-1:0] LAST_BARO  = ADDR_W'(4);
   localparam logic [ADDR_W-1:0] LAST_BATT  = ADDR_W'(10);
   localparam logic [ADDR_W-1:0] LAST_VARIO = ADDR_W'(4);

   // Decoded frame kinds.
   typedef logic [1:0] kind_type;
   localparam kind_type KIND_GPS   = 2'd0;
   localparam kind_type KIND_BARO  = 2'd1;
   localparam kind_type KIND_BATT  = 2'd2;
   localparam kind_type KIND_VARIO = 2'd3;

   // Quantity codes on the result channel.
   typedef logic [3:0] quantity_type;
   localparam quantity_type Q_LAT    = 4'd0;
   localparam quantity_type Q_LON    = 4'd1;
   localparam quantity_type Q_ALT    = 4'd2;
   localparam quantity_type Q_SPEED  = 4'd3;
   localparam quantity_type Q_COURSE = 4'd4;
   localparam quantity_type Q_SATS   = 4'd5;
   localparam quantity_type Q_FIX    = 4'd6;
   localparam quantity_type Q_BARO   = 4'd7;
   localparam quantity_type Q_VOLT   = 4'd8;
   localparam quantity_type Q_AMP    = 4'd9;
   localparam quantity_type Q_MAH    = 4'd10;
   localparam quantity_type Q_PCT    = 4'd11;
   localparam quantity_type Q_VARIO  = 4'd12;

   // Configuration register indexes.
   typedef logic [2:0] csr_index_type;
   localparam csr_index_type CSR_GAP   = 3'd0;
   localparam csr_index_type CSR_GPS   = 3'd1;
   localparam csr_index_type CSR_VARIO = 3'd2;
   localparam csr_index_type CSR_BATT  = 3'd3;
   localparam csr_index_type CSR_BARO  = 3'd4;
   localparam csr_index_type CSR_EN    = 3'd5;

   // One byte of CRC-8 with polynomial 0xD5, MSB first.
   function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] c;
      c = crc ^ b;
      for (int k = 0; k < 8; k++) begin
         c = c[7] ? ((c << 1) ^ 8'hD5) : (c << 1);
      end
      return c;
   endfunction

endpackage

[sv/sensor_frame_decoder.sv]
// Serial telemetry frame decoder. Each word on req_ carries one received byte and its
// microsecond timestamp; bytes are written into a 64-byte frame store, with the
// CRC-8 (poly 0xD5) kept running as they arrive, so a byte is taken every cycle while
// a frame is being received. When the last byte of a frame with a good CRC and an
// enabled, long enough type arrives, the block stops taking bytes, reads the needed
// payload bytes back out of the store one per cycle (2 to 15 reads through the registered
// read port), does the scaling arithmetic in states CALC1 and CALC2, and then issues one
// result word per cycle as rsp_ready allows (7 for GPS, 4 for battery, 1 for baro or
// vario). Input resumes as soon as the last result is loaded into the output register.
// Other bytes, including dropped ones, are taken without a stall. The store needs no clearing.
`include "sensor_frame_decoder_macros.svh"

module sensor_frame_decoder (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [7:0]                 req_rx_byte,
   input  logic [31:0]                req_arrival_time_us,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output sfd_pkg::quantity_type      rsp_quantity,
   output logic signed [31:0]         rsp_reading,
   output logic                       rsp_last_of_frame,
   input  logic                       csr_we,
   input  sfd_pkg::csr_index_type     csr_index,
   input  logic [15:0]                csr_wdata
);
   import sfd_pkg::*;

   localparam logic [2:0] ST_RECV  = 3'd0;
   localparam logic [2:0] ST_READ  = 3'd1;
   localparam logic [2:0] ST_DRAIN = 3'd2;
   localparam logic [2:0] ST_CALC1 = 3'd3;
   localparam logic [2:0] ST_CALC2 = 3'd4;
   localparam logic [2:0] ST_EMIT  = 3'd5;

   // Configuration registers.
   logic [15:0] gap_ff;
   logic [7:0]  gps_code_ff, vario_code_ff, batt_code_ff, baro_code_ff;
   logic [3:0]  enable_ff;

   // Control state.
   logic [2:0]           state_ff, state_in;
   logic [POS_W-1:0]     pos_ff, pos_in;
   logic [31:0]          start_ff, start_in;
   logic [7:0]           len_ff, len_in;
   logic [7:0]           type_ff, type_in;
   logic [7:0]           crc_ff, crc_in;
   kind_type             kind_ff, kind_in;
   logic [ADDR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [ADDR_W-1:0]    rd_last_ff, rd_last_in;
   logic                 pend_ff, pend_in;
   logic [CAP_IDX_W-1:0] pend_idx_ff, pend_idx_in;
   logic [2:0]           emit_k_ff, emit_k_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   // Payload registers.
   logic [7:0]          cap_ff [CAP_BYTES];
   logic [22:0]         spd_x_ff;
   logic [17:0]         spd_ff;
   logic [12:0]         head_ff;
   logic [31:0]         alt_ff;
   quantity_type        rsp_q_ff, q_next;
   logic [31:0]         rsp_val_ff, val_next;
   logic                rsp_last_ff;

   // Receive path signals.
   logic                 accept;
   logic [31:0]          diff;
   logic                 gap_hit;
   logic [POS_W-1:0]     pos_eff, pos_inc;
   logic [8:0]           total;
   logic                 oversize, do_write, frame_end, sel_ok;
   kind_type             sel_kind;
   logic [ADDR_W-1:0]    sel_last;
   logic [7:0]           ram_rdata;
   logic [2:0]           emit_n;
   logic                 out_load, emit_last;
   logic [15:0]          baro_p;
   logic [1:0]           fix;
   logic [47:0]          spd_prod;

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == ST_RECV);

   // Gap check against the frame start, then the position this byte lands at.
   assign diff     = req_arrival_time_us - start_ff;
   assign gap_hit  = !diff[31] && (diff > {16'd0, gap_ff});
   assign pos_eff  = gap_hit ? '0 : pos_ff;
   assign pos_inc  = pos_eff + POS_W'(1);
   assign total    = (pos_eff < POS_W'(3)) ? 9'd5 : ({1'b0, len_ff} + 9'd2);
   assign oversize = total > 9'(FRAME_BYTES_MAX);
   assign do_write = !oversize && (9'(pos_eff) < total);
   assign frame_end = do_write && (9'(pos_inc) == total);

   // Kind selection: the first matching code wins, then enable and length gate it.
   always_comb begin
      sel_kind = KIND_GPS;
      sel_last = LAST_GPS;
      sel_ok   = 1'b0;
      if (type_ff == gps_code_ff) begin
         sel_kind = KIND_GPS;
         sel_last = LAST_GPS;
         sel_ok   = enable_ff[0] && (len_ff >= 8'd17);
      end else if (type_ff == baro_code_ff) begin
         sel_kind = KIND_BARO;
         sel_last = LAST_BARO;
         sel_ok   = enable_ff[1] && (len_ff >= 8'd4);
      end else if (type_ff == batt_code_ff) begin
         sel_kind = KIND_BATT;
         sel_last = LAST_BATT;
         sel_ok   = enable_ff[2] && (len_ff >= 8'd10);
      end else if (type_ff == vario_code_ff) begin
         sel_kind = KIND_VARIO;
         sel_last = LAST_VARIO;
         sel_ok   = enable_ff[3] && (len_ff >= 8'd4);
      end
   end

   sfd_ram #(.WIDTH(8), .DEPTH(FRAME_BYTES_MAX)) u_store (
      .clock   (clock),
      .wr_en   (accept && do_write),
      .wr_addr (pos_eff[ADDR_W-1:0]),
      .wr_data (req_rx_byte),
      .rd_en   (state_ff == ST_READ),
      .rd_addr (rd_ptr_ff),
      .rd_data (ram_rdata)
   );

   // Result count per kind and output register handshake.
   always_comb begin
      case (kind_ff)
         KIND_GPS:  emit_n = 3'd7;
         KIND_BATT: emit_n = 3'd4;
         default:   emit_n = 3'd1;
      endcase
   end
   assign out_load  = !rsp_valid_ff || rsp_ready;
   assign emit_last = (emit_k_ff == emit_n - 3'd1);

   // Next result word from the captured bytes.
   assign baro_p = {cap_ff[0], cap_ff[1]};
   assign fix = (cap_ff[14] >= 8'd4) ? 2'd2 : ((cap_ff[14] >= 8'd2) ? 2'd1 : 2'd0);
   always_comb begin
      q_next   = Q_LAT;
      val_next = '0;
      case (kind_ff)
         KIND_GPS: begin
            case (emit_k_ff)
               3'd0: begin q_next = Q_LAT;
                  val_next = {cap_ff[0], cap_ff[1], cap_ff[2], cap_ff[3]}; end
               3'd1: begin q_next = Q_LON;
                  val_next = {cap_ff[4], cap_ff[5], cap_ff[6], cap_ff[7]}; end
               3'd2: begin q_next = Q_ALT;    val_next = alt_ff; end
               3'd3: begin q_next = Q_SPEED;  val_next = {14'd0, spd_ff}; end
               3'd4: begin q_next = Q_COURSE; val_next = {19'd0, head_ff}; end
               3'd5: begin q_next = Q_SATS;   val_next = {24'd0, cap_ff[14]}; end
               default: begin q_next = Q_FIX; val_next = {30'd0, fix}; end
            endcase
         end
         KIND_BARO: begin
            q_next = Q_BARO;
            if (baro_p[15]) begin
               val_next = 32'({17'd0, baro_p[14:0]}) * 32'd10 - 32'd5;
            end else begin
               val_next = {16'd0, baro_p} - 32'd10000;
            end
         end
         KIND_BATT: begin
            case (emit_k_ff)
               3'd0: begin q_next = Q_VOLT;
                  val_next = {16'd0, cap_ff[0], cap_ff[1]} * 32'd10; end
               3'd1: begin q_next = Q_AMP;
                  val_next = {16'd0, cap_ff[2], cap_ff[3]} * 32'd10; end
               3'd2: begin q_next = Q_MAH;
                  val_next = {8'd0, cap_ff[4], cap_ff[5], cap_ff[6]}; end
               default: begin q_next = Q_PCT; val_next = {24'd0, cap_ff[7]}; end
            endcase
         end
         default: begin
            q_next   = Q_VARIO;
            val_next = {{16{cap_ff[0][7]}}, cap_ff[0], cap_ff[1]};
         end
      endcase
   end

   // Speed divide by 36 as a multiply by the reciprocal, exact for 23-bit inputs.
   assign spd_prod = {25'd0, spd_x_ff} * 48'd14913081;

   // Next-state logic for the control registers.
   always_comb begin
      state_in     = state_ff;
      pos_in       = pos_ff;
      start_in     = start_ff;
      len_in       = len_ff;
      type_in      = type_ff;
      crc_in       = crc_ff;
      kind_in      = kind_ff;
      rd_ptr_in    = rd_ptr_ff;
      rd_last_in   = rd_last_ff;
      pend_in      = 1'b0;
      pend_idx_in  = pend_idx_ff;
      emit_k_in    = emit_k_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      unique case (state_ff)
         ST_RECV: begin
            if (accept) begin
               if (pos_eff == '0) begin
                  start_in = req_arrival_time_us;
               end
               if (oversize) begin
                  pos_in = '0;
               end else if (do_write) begin
                  pos_in = frame_end ? '0 : pos_inc;
                  if (pos_eff == POS_W'(1)) begin
                     len_in = req_rx_byte;
                  end
                  if (pos_eff == POS_W'(2)) begin
                     type_in = req_rx_byte;
                     crc_in  = crc8_step(8'd0, req_rx_byte);
                  end
                  if (pos_eff >= POS_W'(3) && !frame_end) begin
                     crc_in = crc8_step(crc_ff, req_rx_byte);
                  end
                  if (frame_end && (crc_ff == req_rx_byte) && sel_ok) begin
                     state_in   = ST_READ;
                     kind_in    = sel_kind;
                     rd_last_in = sel_last;
                     rd_ptr_in  = FIRST_DATA;
                  end
               end else begin
                  pos_in = pos_eff;
               end
            end
         end
         ST_READ: begin
            pend_in     = 1'b1;
            pend_idx_in = CAP_IDX_W'(rd_ptr_ff - FIRST_DATA);
            rd_ptr_in   = rd_ptr_ff + ADDR_W'(1);
            if (rd_ptr_ff == rd_last_ff) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: state_in = ST_CALC1;
         ST_CALC1: state_in = ST_CALC2;
         ST_CALC2: begin
            state_in  = ST_EMIT;
            emit_k_in = '0;
         end
         ST_EMIT: begin
            if (out_load) begin
               rsp_valid_in = 1'b1;
               emit_k_in    = emit_k_ff + 3'd1;
               if (emit_last) begin
                  state_in = ST_RECV;
               end
            end
         end
         default: state_in = ST_RECV;
      endcase
   end

   // Control and configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_RECV;
         pos_ff        <= '0;
         start_ff      <= '0;
         pend_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         gap_ff        <= 16'd1750;
         gps_code_ff   <= 8'd2;
         vario_code_ff <= 8'd7;
         batt_code_ff  <= 8'd8;
         baro_code_ff  <= 8'd9;
         enable_ff     <= 4'hF;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         start_ff     <= start_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            unique case (csr_index)
               CSR_GAP:   gap_ff        <= csr_wdata;
               CSR_GPS:   gps_code_ff   <= csr_wdata[7:0];
               CSR_VARIO: vario_code_ff <= csr_wdata[7:0];
               CSR_BATT:  batt_code_ff  <= csr_wdata[7:0];
               CSR_BARO:  baro_code_ff  <= csr_wdata[7:0];
               CSR_EN:    enable_ff     <= csr_wdata[3:0];
               default: ;
            endcase
         end
      end
   end

   // Payload registers: frame fields, captured bytes, arithmetic and the result word.
   always_ff @(posedge clock) begin
      len_ff      <= len_in;
      type_ff     <= type_in;
      crc_ff      <= crc_in;
      kind_ff     <= kind_in;
      rd_ptr_ff   <= rd_ptr_in;
      rd_last_ff  <= rd_last_in;
      pend_idx_ff <= pend_idx_in;
      emit_k_ff   <= emit_k_in;
      if (pend_ff) begin
         cap_ff[pend_idx_ff] <= ram_rdata;
      end
      if (state_ff == ST_CALC1) begin
         spd_x_ff <= 23'({16'd0, cap_ff[8], cap_ff[9]} * 32'd100 + 32'd18);
         head_ff  <= 13'(({16'd0, cap_ff[10], cap_ff[11]} * 32'd52429) >> 19);
         alt_ff   <= ({16'd0, cap_ff[12], cap_ff[13]} - 32'd1000) * 32'd100;
      end
      if (state_ff == ST_CALC2) begin
         spd_ff <= 18'(spd_prod >> 29);
      end
      if (state_ff == ST_EMIT && out_load) begin
         rsp_q_ff    <= q_next;
         rsp_val_ff  <= val_next;
         rsp_last_ff <= emit_last;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_quantity      = rsp_q_ff;
   assign rsp_reading       = rsp_val_ff;
   assign rsp_last_of_frame = rsp_last_ff;

   // Checks on the sequencer.
   `SFD_ASSERT_ALWAYS(a_pos_range, pos_ff <= POS_W'(FRAME_BYTES_MAX), "write position past store")
   `SFD_ASSERT_ALWAYS(a_emit_range, (state_ff != ST_EMIT) || (emit_k_ff < emit_n), "emit index overrun")
   `SFD_ASSERT_ALWAYS(a_read_range, (state_ff != ST_READ) || ((rd_ptr_ff >= FIRST_DATA) && (rd_ptr_ff <= rd_last_ff)), "read pointer out of range")
   `SFD_ASSERT_NEXT(a_last_done, (state_ff == ST_EMIT) && out_load && emit_last, (state_ff == ST_RECV) && rsp_valid_ff && rsp_last_ff, "frame end not released")

endmodule

[sv/sfd_ram.sv]
module sfd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule
